[rtl/arma_seg_pkg.sv]
// Shared types and constants of the ARMA segment likelihood unit.
package arma_seg_pkg;

    localparam int DEF_MAX_AR = 4;
    localparam int DEF_MAX_MA = 4;
    localparam int DEF_COUNT_BITS = 32;

    localparam int SAMPLE_W = 32;
    localparam int COEF_W = 18;
    localparam int ORD_W = 3;
    localparam int SLOT_W = 3;
    localparam int NLL_W = 64;
    // Running AR/MA sum at Q.32 with headroom for sixteen lags of each kind.
    localparam int ACC_W = 56;
    localparam int MUL_W = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes.
    localparam logic [2:0] REG_AR_ORDER = 3'd0;
    localparam logic [2:0] REG_MA_ORDER = 3'd1;
    localparam logic [2:0] REG_HALF_INV_VAR = 3'd2;
    localparam logic [2:0] REG_LOG_TERM = 3'd3;

    // Item kinds carried in tuser.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_RES,
        ST_SQR,
        ST_ACC,
        ST_M_LO,
        ST_M_HI,
        ST_M_SQH,
        ST_M_SQL,
        ST_COMB,
        ST_OUT
    } state_t;

    // Control broadcast from the sequencer to every lag cell.
    typedef struct packed {
        logic shift;
        logic clear;
        logic load_ar;
        logic load_ma;
        logic [1:0] lag;
        logic signed [COEF_W-1:0] coef;
        logic [ORD_W-1:0] p;
        logic [ORD_W-1:0] q;
    } cell_ctrl_t;

endpackage

[rtl/arma_seg_cell.sv]
// One lag cell: holds a past sample, a past residual and their coefficients.
module arma_seg_cell #(
    parameter int IDX = 0,
    parameter bit HAS_AR = 1'b1,
    parameter bit HAS_MA = 1'b1
) (
    input  logic clk,
    input  logic rst_n,
    input  arma_seg_pkg::cell_ctrl_t ctrl,
    input  logic signed [arma_seg_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [arma_seg_pkg::SAMPLE_W-1:0] resid_in,
    input  logic signed [arma_seg_pkg::ACC_W-1:0] acc_in,
    output logic signed [arma_seg_pkg::SAMPLE_W-1:0] sample_out,
    output logic signed [arma_seg_pkg::SAMPLE_W-1:0] resid_out,
    output logic signed [arma_seg_pkg::ACC_W-1:0] acc_out
);
    import arma_seg_pkg::*;

    localparam logic [4:0] IDX_V = 5'(IDX);

    logic signed [COEF_W-1:0] ar_coef_reg;
    logic signed [COEF_W-1:0] ma_coef_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] resid_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [COEF_W+SAMPLE_W-1:0] ar_prod;
    logic signed [COEF_W+SAMPLE_W-1:0] ma_prod;
    logic use_ar;
    logic use_ma;
    logic lag_hit;

    // This lag takes part only when it lies within the current orders.
    assign use_ar = HAS_AR && (IDX_V < {2'b00, ctrl.p});
    assign use_ma = HAS_MA && (IDX_V < {2'b00, ctrl.q});
    assign lag_hit = (5'(ctrl.lag) == IDX_V);

    // Subtract this lag's AR and MA terms from the sum passing by.
    assign ar_prod = ar_coef_reg * sample_reg;
    assign ma_prod = ma_coef_reg * resid_reg;

    always_comb
    begin
        acc_next = acc_in;
        if (use_ar)
        begin
            acc_next = acc_next - ACC_W'(ar_prod);
        end
        if (use_ma)
        begin
            acc_next = acc_next - ACC_W'(ma_prod);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Coefficients survive segment ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ar_coef_reg <= '0;
            ma_coef_reg <= '0;
        end
        else
        begin
            if (HAS_AR && ctrl.load_ar && lag_hit)
            begin
                ar_coef_reg <= ctrl.coef;
            end
            if (HAS_MA && ctrl.load_ma && lag_hit)
            begin
                ma_coef_reg <= ctrl.coef;
            end
        end
    end

    // Delay line taps move one cell along per sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            resid_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            sample_reg <= '0;
            resid_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            sample_reg <= sample_in;
            resid_reg <= resid_in;
        end
    end

    assign sample_out = sample_reg;
    assign resid_out = resid_reg;
    assign acc_out = acc_reg;

endmodule

[rtl/arma_seg_mul.sv]
// Shared signed 33 by 33 multiplier with a registered product.
module arma_seg_mul (
    input  logic clk,
    input  logic signed [arma_seg_pkg::MUL_W-1:0] a,
    input  logic signed [arma_seg_pkg::MUL_W-1:0] b,
    output logic signed [arma_seg_pkg::PROD_W-1:0] prod
);
    import arma_seg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // One product per cycle, taken by the sequencer in the cycle after its operands.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[rtl/arma_segment_nll_unit.sv]
// Top level of the streaming ARMA segment negative log-likelihood unit.
//
// Input stream (s_*): one item per transfer. s_tuser selects a data sample
// or a coefficient load; s_tlast marks the final sample of a segment.
// A coefficient load leaves the input ready and gives no result.
// A data sample keeps the input busy until its residual is accumulated:
// the partial AR/MA sum ripples through one lag cell per cycle, then the
// residual is rounded, squared on the shared multiplier and accumulated.
// A final sample then passes ST_M_LO, ST_M_HI, ST_M_SQH, ST_M_SQL and
// ST_COMB for the four partial products of the likelihood, which all go
// through that single 33x33 multiplier; a final sample of a short segment
// goes straight to ST_OUT. m_tvalid rises in the cycle after ST_OUT emits.
// Output stream (m_*): one result per segment, held in an output register.
// While a result waits for m_tready the unit keeps taking samples of the
// next segment; only the next final sample waits for the register to free.
// Configuration writes (cfg_*) are always ready and must come while idle.
// Reset clears the coefficients, the delay line, the running sums and the
// configuration to its defaults; the unit is ready as soon as reset is released.
module arma_segment_nll_unit #(
    parameter int MAX_AR_ORDER = arma_seg_pkg::DEF_MAX_AR,
    parameter int MAX_MA_ORDER = arma_seg_pkg::DEF_MAX_MA,
    parameter int COUNT_BITS = arma_seg_pkg::DEF_COUNT_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [55:0] s_tdata,  // coef_slot[2:0], coef_value[20:3], sample[52:21], zeros
    input  logic [0:0] s_tuser,   // func[0]
    input  logic s_tlast,         // last
    output logic m_tvalid,
    input  logic m_tready,
    output logic [63:0] m_tdata,  // nll[63:0]
    output logic [1:0] m_tuser,   // short_segment[0], overflow[1]
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import arma_seg_pkg::*;

    localparam int NCELL = (MAX_AR_ORDER > MAX_MA_ORDER) ? MAX_AR_ORDER : MAX_MA_ORDER;
    localparam int CYC_W = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam logic [ORD_W-1:0] MAX_P = ORD_W'(MAX_AR_ORDER > 7 ? 7 : MAX_AR_ORDER);
    localparam logic [ORD_W-1:0] MAX_Q = ORD_W'(MAX_MA_ORDER > 7 ? 7 : MAX_MA_ORDER);
    localparam int A_W = 82;

    // Configuration registers.
    logic [ORD_W-1:0] ar_order_reg;
    logic [ORD_W-1:0] ma_order_reg;
    logic [31:0] hiv_reg;
    logic signed [31:0] log_term_reg;

    // Sequencer and segment state.
    state_t state_reg;
    state_t state_next;
    logic [CYC_W-1:0] cyc_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic last_reg;
    logic signed [SAMPLE_W-1:0] resid_reg;
    logic active_reg;
    logic res_ov_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [63:0] sumsq_reg;
    logic ov_seen_reg;
    logic short_reg;
    logic signed [PROD_W-1:0] plo_reg;
    logic signed [PROD_W-1:0] phi_reg;
    logic [63:0] hh_reg;
    logic signed [63:0] a_reg;
    logic signed [63:0] b_reg;
    logic calc_ov_reg;

    // Output register.
    logic out_valid_reg;
    logic [NLL_W-1:0] nll_out_reg;
    logic short_out_reg;
    logic ov_out_reg;

    logic in_xfer;
    logic out_free;
    logic emit;
    logic [ORD_W-1:0] p_eff;
    logic [ORD_W-1:0] q_eff;
    logic [ORD_W-1:0] m_eff;
    cell_ctrl_t ctrl;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [SAMPLE_W-1:0] samp_chain [NCELL];
    logic signed [SAMPLE_W-1:0] resid_chain [NCELL];
    logic signed [ACC_W-1:0] acc_chain [NCELL];
    logic signed [ACC_W-1:0] acc_head;

    logic signed [ACC_W-1:0] r_rnd;
    logic signed [ACC_W-16-1:0] r_full;
    logic signed [SAMPLE_W-1:0] r_sat;
    logic r_ov;
    logic [47:0] sq;
    logic [63:0] sum_new;
    logic [COUNT_BITS-1:0] cnt_new;
    logic cnt_ov;
    logic signed [63:0] d_val;
    logic [47:0] ll;
    logic signed [A_W-1:0] a_full;
    logic [63:0] s_val;
    logic signed [64:0] tot;
    logic [NLL_W-1:0] nll_val;
    logic tot_ov;

    assign in_xfer = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || m_tready;
    assign emit = (state_reg == ST_OUT) && out_free;

    // Orders clamped to the lags that exist.
    assign p_eff = (ar_order_reg > MAX_P) ? MAX_P : ar_order_reg;
    assign q_eff = (ma_order_reg > MAX_Q) ? MAX_Q : ma_order_reg;
    assign m_eff = (p_eff > q_eff) ? p_eff : q_eff;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ar_order_reg <= ORD_W'(1);
            ma_order_reg <= ORD_W'(1);
            hiv_reg <= 32'd32768;
            log_term_reg <= 32'sd60224;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_AR_ORDER:     ar_order_reg <= cfg_data[ORD_W-1:0];
                REG_MA_ORDER:     ma_order_reg <= cfg_data[ORD_W-1:0];
                REG_HALF_INV_VAR: hiv_reg <= cfg_data;
                REG_LOG_TERM:     log_term_reg <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    // Cell control: loads, shifting of the delay line and segment clear.
    always_comb
    begin
        ctrl.shift = (state_reg == ST_ACC);
        ctrl.clear = emit;
        ctrl.load_ar = in_xfer && (s_tuser[0] == FUNC_LOAD) && !s_tdata[2];
        ctrl.load_ma = in_xfer && (s_tuser[0] == FUNC_LOAD) && s_tdata[2];
        ctrl.lag = s_tdata[1:0];
        ctrl.coef = $signed(s_tdata[20:3]);
        ctrl.p = p_eff;
        ctrl.q = q_eff;
    end

    // The row of lag cells; the running sum enters at the first lag.
    assign acc_head = {{(ACC_W-48){x_reg[SAMPLE_W-1]}}, x_reg, 16'b0};

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            arma_seg_cell #(
                .IDX(i),
                .HAS_AR(i < MAX_AR_ORDER),
                .HAS_MA(i < MAX_MA_ORDER)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .ctrl(ctrl),
                .sample_in(x_reg),
                .resid_in(resid_reg),
                .acc_in(acc_head),
                .sample_out(samp_chain[i]),
                .resid_out(resid_chain[i]),
                .acc_out(acc_chain[i])
            );
        end
        else
        begin : g_next
            arma_seg_cell #(
                .IDX(i),
                .HAS_AR(i < MAX_AR_ORDER),
                .HAS_MA(i < MAX_MA_ORDER)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .ctrl(ctrl),
                .sample_in(samp_chain[i-1]),
                .resid_in(resid_chain[i-1]),
                .acc_in(acc_chain[i-1]),
                .sample_out(samp_chain[i]),
                .resid_out(resid_chain[i]),
                .acc_out(acc_chain[i])
            );
        end
    end

    arma_seg_mul u_mul (
        .clk(clk),
        .a(mul_a),
        .b(mul_b),
        .prod(prod)
    );

    // Residual: round to Q16.16 and saturate to 32 bits.
    assign r_rnd = acc_chain[NCELL-1] + ACC_W'(32768);
    assign r_full = r_rnd[ACC_W-1:16];
    always_comb
    begin
        r_ov = 1'b0;
        r_sat = r_full[SAMPLE_W-1:0];
        if (r_full[ACC_W-17:SAMPLE_W-1] != {(ACC_W-16-SAMPLE_W+1){r_full[ACC_W-17]}})
        begin
            r_ov = 1'b1;
            r_sat = r_full[ACC_W-17] ? $signed({1'b1, {(SAMPLE_W-1){1'b0}}})
                                      : $signed({1'b0, {(SAMPLE_W-1){1'b1}}});
        end
    end

    // Square accumulation and sample count.
    assign sq = 48'((prod[63:0] + 64'd32768) >> 16);
    assign sum_new = sumsq_reg + {16'b0, sq};
    assign cnt_ov = (count_reg == {COUNT_BITS{1'b1}});
    assign cnt_new = cnt_ov ? count_reg : count_reg + COUNT_BITS'(1);

    // Likelihood terms.
    assign d_val = $signed(64'(count_reg)) - 64'sd2;
    assign ll = 48'((prod[63:0] + 64'd32768) >> 16);
    assign a_full = (A_W'(phi_reg) <<< 24) + A_W'(plo_reg);
    assign s_val = {hh_reg[47:0], 16'b0} + {16'b0, ll};
    assign tot = 65'(a_reg) + 65'(b_reg);
    assign tot_ov = (tot[64] != tot[63]);
    assign nll_val = tot_ov ? (tot[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}}) : tot[63:0];

    // Next state and multiplier operands.
    always_comb
    begin
        state_next = state_reg;
        mul_a = MUL_W'(resid_reg);
        mul_b = MUL_W'(resid_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_tuser[0] == FUNC_SAMPLE))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (cyc_reg == CYC_W'(NCELL - 1))
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:  state_next = ST_SQR;
            ST_SQR:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (cnt_new <= COUNT_BITS'(m_eff))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_M_LO;
                end
            end
            ST_M_LO:
            begin
                mul_a = MUL_W'(log_term_reg);
                mul_b = $signed({9'b0, d_val[23:0]});
                state_next = ST_M_HI;
            end
            ST_M_HI:
            begin
                mul_a = MUL_W'(log_term_reg);
                mul_b = d_val[24+MUL_W-1:24];
                state_next = ST_M_SQH;
            end
            ST_M_SQH:
            begin
                mul_a = $signed({1'b0, sumsq_reg[63:32]});
                mul_b = $signed({1'b0, hiv_reg});
                state_next = ST_M_SQL;
            end
            ST_M_SQL:
            begin
                mul_a = $signed({1'b0, sumsq_reg[31:0]});
                mul_b = $signed({1'b0, hiv_reg});
                state_next = ST_COMB;
            end
            ST_COMB: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Segment state: lag step counter, count, sum of squares, overflow flag and short flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_reg <= '0;
            count_reg <= '0;
            sumsq_reg <= '0;
            ov_seen_reg <= 1'b0;
            short_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_IDLE)
            begin
                cyc_reg <= '0;
            end
            else if (state_reg == ST_SUM)
            begin
                cyc_reg <= cyc_reg + CYC_W'(1);
            end
            if (state_reg == ST_ACC)
            begin
                count_reg <= cnt_new;
                short_reg <= (cnt_new <= COUNT_BITS'(m_eff));
                if (active_reg)
                begin
                    if (sum_new[63])
                    begin
                        sumsq_reg <= {1'b0, {63{1'b1}}};
                    end
                    else
                    begin
                        sumsq_reg <= sum_new;
                    end
                end
                ov_seen_reg <= ov_seen_reg | res_ov_reg | (active_reg & sum_new[63]) | cnt_ov;
            end
            else if (emit)
            begin
                count_reg <= '0;
                sumsq_reg <= '0;
                ov_seen_reg <= 1'b0;
            end
        end
    end

    // Per-sample and per-result working registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg <= $signed(s_tdata[52:21]);
            last_reg <= s_tlast;
        end
        if (state_reg == ST_RES)
        begin
            active_reg <= (count_reg >= COUNT_BITS'(m_eff));
            resid_reg <= (count_reg >= COUNT_BITS'(m_eff)) ? r_sat : '0;
            res_ov_reg <= (count_reg >= COUNT_BITS'(m_eff)) && r_ov;
        end
        if (state_reg == ST_M_HI)
        begin
            plo_reg <= prod;
        end
        if (state_reg == ST_M_SQH)
        begin
            phi_reg <= prod;
        end
        if (state_reg == ST_M_SQL)
        begin
            hh_reg <= prod[63:0];
        end
        if (state_reg == ST_COMB)
        begin
            calc_ov_reg <= 1'b0;
            if (a_full[A_W-1:63] != {(A_W-63){a_full[63]}})
            begin
                a_reg <= a_full[A_W-1] ? $signed({1'b1, 63'b0}) : $signed({1'b0, {63{1'b1}}});
                calc_ov_reg <= 1'b1;
            end
            else
            begin
                a_reg <= a_full[63:0];
            end
            if ((hh_reg >= 64'h0000_8000_0000_0000) || s_val[63])
            begin
                b_reg <= $signed({1'b0, {63{1'b1}}});
                calc_ov_reg <= 1'b1;
            end
            else
            begin
                b_reg <= $signed(s_val);
            end
        end
        if (emit)
        begin
            nll_out_reg <= short_reg ? '0 : nll_val;
            short_out_reg <= short_reg;
            ov_out_reg <= ov_seen_reg | (!short_reg & (calc_ov_reg | tot_ov));
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = nll_out_reg;
    assign m_tuser = {ov_out_reg, short_out_reg};

`ifndef NO_ASSERTIONS
    // The saturated sum of squares never reaches the sign bit.
    a_sumsq_top: assert property (@(posedge clk) disable iff (!rst_n) !sumsq_reg[63])
        else $error("sum of squares exceeded 63 bits");

    // Emitting a result leaves a cleared segment behind.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (count_reg == '0) && (sumsq_reg == '0) && !ov_seen_reg)
        else $error("segment state not cleared after result");

    // A short segment result always carries a zero likelihood.
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("short segment with nonzero likelihood");

    // A result is only produced for a final sample.
    a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> last_reg)
        else $error("result without a final sample");
`endif

endmodule
